@@ design/bba_pkg.sv @@
// package for the block bitmap allocator
// holds request/result types, mode and status codes, default map size
package bba_pkg;

    localparam int NUM_BLOCKS_DEF = 128;

    // block number plus length, or NUM_BLOCKS itself, fits in nine bits
    localparam int CW = 9;

    typedef enum logic [1:0] {
        MODE_CONTIG  = 2'd0,
        MODE_INDEXED = 2'd1,
        MODE_LINKED  = 2'd2,
        MODE_RSVD    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_PENDING   = 3'd0,
        ST_ALLOCATED = 3'd1,
        ST_RANGE     = 3'd2,
        ST_IN_USE    = 3'd3,
        ST_IGNORED   = 3'd4
    } status_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] block;
        logic [7:0] length;
        logic       first;
        logic       last;
    } req_t;

    typedef struct packed {
        status_t status;
        logic    run_done;
    } res_t;

endpackage

@@ design/bba_engine.sv @@
// allocation engine: used map, pending map and run flag in flops
// one request word evaluated per step; depends on bba_pkg
module bba_engine #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  bba_pkg::req_t req,
    output bba_pkg::res_t res
);
    import bba_pkg::*;

    logic [NUM_BLOCKS-1:0] used_reg, used_next;
    logic [NUM_BLOCKS-1:0] pend_reg, pend_next;
    logic                  failed_reg, failed_next;

    logic [NUM_BLOCKS-1:0] range_mask;
    logic [NUM_BLOCKS-1:0] blk_onehot;
    logic [NUM_BLOCKS-1:0] pend_eff;
    logic [CW-1:0]         blk_w;
    logic [CW-1:0]         end_w;
    logic                  failed_eff;
    logic                  overrun;
    logic                  blk_bad;
    logic                  blk_used;

    assign blk_w   = {1'b0, req.block};
    assign end_w   = blk_w + {1'b0, req.length};
    assign overrun = end_w > CW'(NUM_BLOCKS);
    assign blk_bad = blk_w >= CW'(NUM_BLOCKS);

    // per-block decode of the contiguous range and of the single block
    always_comb begin
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            range_mask[i] = (CW'(i) >= blk_w) && (CW'(i) < end_w);
            blk_onehot[i] = (CW'(i) == blk_w);
        end
    end

    assign blk_used   = |(used_reg & blk_onehot);
    assign pend_eff   = req.first ? '0 : pend_reg;
    assign failed_eff = req.first ? 1'b0 : failed_reg;

    always_comb begin
        used_next    = used_reg;
        pend_next    = pend_reg;
        failed_next  = failed_reg;
        res.status   = ST_IGNORED;
        res.run_done = 1'b1;
        case (req.mode)
            MODE_CONTIG: begin
                if (overrun) begin
                    res.status = ST_RANGE;
                end else if (|(used_reg & range_mask)) begin
                    res.status = ST_IN_USE;
                end else begin
                    used_next  = used_reg | range_mask;
                    res.status = ST_ALLOCATED;
                end
            end
            MODE_INDEXED, MODE_LINKED: begin
                pend_next    = pend_eff;
                failed_next  = failed_eff;
                res.run_done = req.last;
                if (failed_eff) begin
                    res.status = ST_IGNORED;
                end else if (blk_bad) begin
                    res.status  = ST_RANGE;
                    pend_next   = '0;
                    failed_next = 1'b1;
                end else if (blk_used) begin
                    res.status  = ST_IN_USE;
                    pend_next   = '0;
                    failed_next = 1'b1;
                end else begin
                    if (req.mode == MODE_INDEXED) begin
                        pend_next = pend_eff | blk_onehot;
                    end else begin
                        used_next = used_reg | blk_onehot;
                    end
                    if (req.last) begin
                        // indexed run commits its whole pending set
                        if (req.mode == MODE_INDEXED) begin
                            used_next = used_reg | pend_next;
                        end
                        res.status = ST_ALLOCATED;
                    end else begin
                        res.status = ST_PENDING;
                    end
                end
                if (req.last) begin
                    pend_next   = '0;
                    failed_next = 1'b0;
                end
            end
            default: begin
                res.status   = ST_IGNORED;
                res.run_done = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg   <= '0;
            pend_reg   <= '0;
            failed_reg <= 1'b0;
        end else if (step) begin
            used_reg   <= used_next;
            pend_reg   <= pend_next;
            failed_reg <= failed_next;
        end
    end

endmodule

@@ design/block_bitmap_allocator.sv @@
// top level of the free-block bitmap allocator
// input register, allocation engine (bba_engine) and result register; uses bba_pkg
//
//  channel | ports                                        | direction | meaning
//  s_      | s_valid s_ready s_mode s_block s_length       | in        | request word
//          | s_first s_last                               |           |
//  m_      | m_valid m_ready m_status m_run_done          | out       | result word
//
// every request passes the input register and the engine into the result register before its result word shows
// one word per cycle sustained while m_ready stays high: the engine updates the bitmap flops in one pass
// reset (aresetn low, synchronous) frees every block and clears the run state
// a stalled result holds in the output register; the input register holds
// one more word, so s_ready drops only while both are full and m_ready is low
module block_bitmap_allocator #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_block,
    input  logic [7:0] s_length,
    input  logic       s_first,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic       m_run_done
);
    import bba_pkg::*;

    // input register
    logic in_valid_reg;
    req_t in_req_reg;

    // result register
    logic out_valid_reg;
    res_t out_res_reg;

    res_t eng_res;
    logic advance;

    // the engine fires when the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg <= '{mode:   mode_t'(s_mode),
                            block:  s_block,
                            length: s_length,
                            first:  s_first,
                            last:   s_last};
        end
    end

    bba_engine #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .req     (in_req_reg),
        .res     (eng_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= eng_res;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_status   = out_res_reg.status;
    assign m_run_done = out_res_reg.run_done;

endmodule

@@ design/bba_checker.sv @@
// port-level checks for the block bitmap allocator
// bound to block_bitmap_allocator; uses bba_pkg status codes
module bba_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_status,
    input logic       m_run_done
);
    import bba_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_run_done))
        else $error("result word changed while stalled");

    // status codes stay in the defined set
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= ST_IGNORED))
        else $error("undefined status code");

    // a pending status never closes a run
    a_pending_open: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_PENDING) |-> !m_run_done)
        else $error("pending result marked as run end");

    // after reset nothing is shown and a word can be taken
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("outputs not cleared by reset");

endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (.*);
